@@ sv/amb_pkg.sv @@
// Shared types, register indexes and saturating helpers for the escape-time block.
package amb_pkg;

  // Register indexes on the configuration write port.
  localparam logic [1:0] CFG_PIXEL_STEP = 2'd0;
  localparam logic [1:0] CFG_OFFSET_X   = 2'd1;
  localparam logic [1:0] CFG_OFFSET_Y   = 2'd2;
  localparam logic [1:0] CFG_MAX_ITER   = 2'd3;

  // Field widths fixed by the interface.
  localparam int unsigned PIX_W   = 10;
  localparam int unsigned COUNT_W = 10;
  localparam int unsigned STEP_W  = 31;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned PROD_W  = 64;

  // Saturation limits, held at product width and at value width.
  localparam logic signed [PROD_W-1:0] MAX64 = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] MIN64 = -64'sd2147483648;
  localparam logic signed [VAL_W-1:0]  MAX32 = 32'sh7FFFFFFF;
  localparam logic signed [VAL_W-1:0]  MIN32 = 32'sh80000000;

  // Configuration as seen by the iteration core.
  typedef struct packed {
    logic [STEP_W-1:0]         pixel_step;
    logic signed [VAL_W-1:0]   offset_x;
    logic signed [VAL_W-1:0]   offset_y;
    logic [COUNT_W-1:0]        max_iterations;
  } amb_cfg_t;

  // One finished pixel.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               escaped;
    logic [PIX_W-1:0]   x;
    logic [PIX_W-1:0]   y;
  } amb_res_t;

  // Clamp a wide signed value to the 32-bit range.
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > MAX64) begin
      r = MAX32;
    end else if (v < MIN64) begin
      r = MIN32;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  // Absolute value where the most negative number maps to the largest positive one.
  function automatic logic signed [VAL_W-1:0] abs_sat(input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v == MIN32) begin
      r = MAX32;
    end else if (v < 0) begin
      r = -v;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ sv/amb_mul.sv @@
// Shared signed 32x32 multiplier with a registered 64-bit product.
module amb_mul
  import amb_pkg::*;
(
  input  logic                     clk,
  input  logic signed [VAL_W-1:0]  a,
  input  logic signed [VAL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

@@ sv/amb_core.sv @@
// Sequencer and datapath that run the escape loop for one pixel on the shared multiplier.
module amb_core
  import amb_pkg::*;
#(
  parameter int IMAGE_SIZE    = 800,
  parameter int FRACTION_BITS = 27
) (
  input  logic             clk,
  input  logic             rst,
  input  amb_cfg_t         cfg,
  input  logic             start,
  input  logic [PIX_W-1:0] pixel_x,
  input  logic [PIX_W-1:0] pixel_y,
  output logic             idle,
  output logic             res_valid,
  input  logic             res_ready,
  output amb_res_t         res
);

  localparam logic signed [VAL_W-1:0]  HALF = VAL_W'(IMAGE_SIZE / 2);
  localparam logic signed [PROD_W-1:0] FOUR = 64'sd1 <<< (FRACTION_BITS + 2);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MX   = 4'd1;
  localparam logic [3:0] S_MY   = 4'd2;
  localparam logic [3:0] S_CI   = 4'd3;
  localparam logic [3:0] S_MRR  = 4'd4;
  localparam logic [3:0] S_MII  = 4'd5;
  localparam logic [3:0] S_MIR  = 4'd6;
  localparam logic [3:0] S_UPD  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]               state;
  logic [3:0]               state_next;
  logic [PIX_W-1:0]         px;
  logic [PIX_W-1:0]         py;
  logic signed [VAL_W-1:0]  cr;
  logic signed [VAL_W-1:0]  ci;
  logic signed [VAL_W-1:0]  zr;
  logic signed [VAL_W-1:0]  zi;
  logic signed [PROD_W-1:0] sr;
  logic signed [PROD_W-1:0] si;
  logic [COUNT_W-1:0]       count;
  logic                     esc_r;

  logic signed [VAL_W-1:0]  mul_a;
  logic signed [VAL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [VAL_W-1:0]  px_off;
  logic signed [VAL_W-1:0]  py_off;
  logic signed [PROD_W-1:0] dbl;
  logic signed [VAL_W-1:0]  zr_new;
  logic signed [VAL_W-1:0]  zi_new;
  logic                     esc;
  logic                     stop;

  // Pixel coordinates relative to the image center.
  assign px_off = $signed({{(VAL_W-PIX_W){1'b0}}, px}) - HALF;
  assign py_off = $signed({{(VAL_W-PIX_W){1'b0}}, py}) - HALF;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state)
      S_MX: begin
        mul_a = px_off;
        mul_b = $signed({1'b0, cfg.pixel_step});
      end
      S_MY: begin
        mul_a = py_off;
        mul_b = $signed({1'b0, cfg.pixel_step});
      end
      S_MRR: begin
        mul_a = zr;
        mul_b = zr;
      end
      S_MII: begin
        mul_a = zi;
        mul_b = zi;
      end
      default: begin
        mul_a = zi;
        mul_b = zr;
      end
    endcase
  end

  amb_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Escape test and next z from the three floored products.
  assign dbl    = prod >>> (FRACTION_BITS - 1);
  assign esc    = (sr + si) >= FOUR;
  assign stop   = (count != '0) && (esc || (count >= cfg.max_iterations));
  assign zr_new = sat32(PROD_W'(sat32(sr)) - PROD_W'(sat32(si)) + PROD_W'(cr));
  assign zi_new = abs_sat(sat32(PROD_W'(sat32(dbl)) + PROD_W'(ci)));

  // Next-state logic.
  always_comb begin
    case (state)
      S_IDLE:  state_next = start ? S_MX : S_IDLE;
      S_MX:    state_next = S_MY;
      S_MY:    state_next = S_CI;
      S_CI:    state_next = S_MRR;
      S_MRR:   state_next = S_MII;
      S_MII:   state_next = S_MIR;
      S_MIR:   state_next = S_UPD;
      S_UPD:   state_next = stop ? S_DONE : S_MRR;
      S_DONE:  state_next = res_ready ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers, loaded as the sequencer walks through a pixel.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          px <= pixel_x;
          py <= pixel_y;
        end
      end
      S_MY: begin
        cr <= abs_sat(sat32(PROD_W'(sat32(prod)) + PROD_W'(cfg.offset_x)));
      end
      S_CI: begin
        ci    <= sat32(PROD_W'(sat32(prod)) + PROD_W'(cfg.offset_y));
        zr    <= '0;
        zi    <= '0;
        count <= '0;
      end
      S_MII: begin
        sr <= prod >>> FRACTION_BITS;
      end
      S_MIR: begin
        si <= prod >>> FRACTION_BITS;
      end
      S_UPD: begin
        if (stop) begin
          esc_r <= esc;
        end else begin
          zr    <= zr_new;
          zi    <= zi_new;
          count <= count + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign idle        = (state == S_IDLE);
  assign res_valid   = (state == S_DONE);
  assign res.count   = count;
  assign res.escaped = esc_r;
  assign res.x       = px;
  assign res.y       = py;

endmodule

@@ sv/abs_variant_mandelbrot_escape_time.sv @@
// Top level: configuration registers, input handshake and output register.
//
// Computes the escape-time count of the absolute-value Mandelbrot variant for one
// pixel per input beat. The setup states S_MX, S_MY and S_CI map the pixel to c.
// Each iteration runs z_r^2, z_i^2 and z_i*z_r on the single 32x32 multiplier,
// then the update and escape test. One more pass runs the test that ends the loop.
// The done state hands the result to the output register, waiting while that
// register cannot take it, and the idle state takes the next pixel.
// One pixel is worked on at a time; in_ready is high only while the core is idle.
// A finished result waits in the output register, so the next pixel can start
// before it is taken.
// Configuration writes must happen only while the block is idle.
module abs_variant_mandelbrot_escape_time
  import amb_pkg::*;
#(
  parameter int IMAGE_SIZE    = 800,
  parameter int FRACTION_BITS = 27
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [VAL_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PIX_W-1:0]   pixel_x,
  input  logic [PIX_W-1:0]   pixel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COUNT_W-1:0] iteration_count,
  output logic               escaped,
  output logic [PIX_W-1:0]   out_x,
  output logic [PIX_W-1:0]   out_y
);

  amb_cfg_t cfg;
  amb_res_t res;
  logic     core_idle;
  logic     res_valid;
  logic     res_ready;
  logic     load;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_step     <= STEP_W'(503316);
      cfg.offset_x       <= '0;
      cfg.offset_y       <= '0;
      cfg.max_iterations <= COUNT_W'(100);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIXEL_STEP: cfg.pixel_step     <= cfg_wdata[STEP_W-1:0];
        CFG_OFFSET_X:   cfg.offset_x       <= $signed(cfg_wdata);
        CFG_OFFSET_Y:   cfg.offset_y       <= $signed(cfg_wdata);
        CFG_MAX_ITER:   cfg.max_iterations <= cfg_wdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready = core_idle;

  amb_core #(
    .IMAGE_SIZE    (IMAGE_SIZE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (in_valid & core_idle),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: takes a result when empty or being drained.
  assign res_ready = !out_valid || out_ready;
  assign load      = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      iteration_count <= res.count;
      escaped         <= res.escaped;
      out_x           <= res.x;
      out_y           <= res.y;
    end
  end

endmodule

@@ bench/tb_abs_variant_mandelbrot_escape_time.sv @@
// Self-checking testbench for the absolute-value Mandelbrot escape-time block.
module tb_abs_variant_mandelbrot_escape_time;
  import amb_pkg::*;

  localparam int IMAGE_SIZE = 800;
  localparam int FRACTION_BITS = 27;
  localparam longint HALF_IMAGE = IMAGE_SIZE / 2;
  localparam longint RADIUS_SQ = longint'(4) << FRACTION_BITS;
  localparam logic [STEP_W-1:0] DEFAULT_STEP = 31'd503316;
  localparam logic [STEP_W-1:0] WIDEST_STEP = 31'h7FFF_FFFF;
  localparam int HOLD_AT_PIXEL = 300;
  localparam int HOLD_CYCLES = 1500;
  localparam int REPORT_LIMIT = 10;

  typedef enum logic [1:0] {SLOW_RECEIVER, SLOW_SENDER, FULL_RATE} idle_mode_t;

  typedef struct {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
  } pixel_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_PIXEL_STEP;
  logic [VAL_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [PIX_W-1:0]   pixel_x = '0;
  logic [PIX_W-1:0]   pixel_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [COUNT_W-1:0] iteration_count;
  logic               escaped;
  logic [PIX_W-1:0]   out_x;
  logic [PIX_W-1:0]   out_y;

  abs_variant_mandelbrot_escape_time #(
    .IMAGE_SIZE(IMAGE_SIZE),
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .iteration_count(iteration_count),
    .escaped(escaped),
    .out_x(out_x),
    .out_y(out_y)
  );

  // Local copy of the block's registers, updated on every write.
  logic [STEP_W-1:0]       step_q = DEFAULT_STEP;
  logic signed [VAL_W-1:0] pan_x = '0;
  logic signed [VAL_W-1:0] pan_y = '0;
  logic [COUNT_W-1:0]      iter_limit = 10'd100;

  pixel_t   pending_pixels[$];
  amb_res_t expected_pixels[$];

  int     pixels_accepted = 0;
  int     results_checked = 0;
  int     escaped_seen = 0;
  int     limit_hits = 0;
  int     longest_run = 0;
  int     mismatches = 0;
  int     settings_used = 0;
  int     recv_hold_left = 0;
  bit     hold_done = 1'b0;
  longint work_budget = 0;
  longint cycle_count = 0;

  // Clock with a period of 10.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Clamp a 64-bit value into the signed 32-bit range.
  function automatic int clamp32(input longint v);
    if (v > longint'(MAX32)) return MAX32;
    if (v < longint'(MIN32)) return MIN32;
    return int'(v);
  endfunction

  // Magnitude with the most negative value pinned to the largest positive one.
  function automatic int mag32(input int v);
    if (v == MIN32) return MAX32;
    return (v < 0) ? -v : v;
  endfunction

  // Escape-time count for one pixel under the current register values.
  function automatic amb_res_t escape_time(input pixel_t p);
    longint px, py, step_l, sr, si, dbl;
    int cr, ci, zr, zi, nr;
    int unsigned steps;
    bit esc, done;
    amb_res_t r;
    px = p.x;
    py = p.y;
    step_l = step_q;
    cr = mag32(clamp32(longint'(clamp32((px - HALF_IMAGE) * step_l)) + longint'(pan_x)));
    ci = clamp32(longint'(clamp32((py - HALF_IMAGE) * step_l)) + longint'(pan_y));
    zr = 0;
    zi = 0;
    steps = 0;
    esc = 1'b0;
    done = 1'b0;
    // The first step always runs; afterwards stop on escape or at the limit.
    while (!done) begin
      sr = (longint'(zr) * longint'(zr)) >>> FRACTION_BITS;
      si = (longint'(zi) * longint'(zi)) >>> FRACTION_BITS;
      esc = (sr + si) >= RADIUS_SQ;
      if (steps > 0 && (esc || steps >= iter_limit)) begin
        done = 1'b1;
      end else begin
        dbl = (longint'(zi) * longint'(zr)) >>> (FRACTION_BITS - 1);
        nr = clamp32(longint'(clamp32(sr)) - longint'(clamp32(si)) + longint'(cr));
        zi = mag32(clamp32(longint'(clamp32(dbl)) + longint'(ci)));
        zr = nr;
        steps++;
      end
    end
    r.count = steps[COUNT_W-1:0];
    r.escaped = esc;
    r.x = p.x;
    r.y = p.y;
    return r;
  endfunction

  // Idle percentage per side; the pattern follows how many beats went in.
  function automatic int idle_pct(input int accepted, input bit sender);
    idle_mode_t m;
    m = (accepted < 520) ? SLOW_RECEIVER : (accepted < 1040) ? SLOW_SENDER : FULL_RATE;
    case (m)
      SLOW_RECEIVER: return sender ? 19 : 73;
      SLOW_SENDER:   return sender ? 73 : 19;
      default:       return 0;
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] random_coord();
    // Mostly inside the image, now and then beyond its edge.
    if ($urandom_range(15) == 0) return PIX_W'($urandom_range(1023, IMAGE_SIZE));
    return PIX_W'($urandom_range(IMAGE_SIZE - 1, 0));
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [VAL_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PIXEL_STEP: step_q = data[STEP_W-1:0];
      CFG_OFFSET_X:   pan_x = data;
      CFG_OFFSET_Y:   pan_y = data;
      CFG_MAX_ITER:   iter_limit = data[COUNT_W-1:0];
      default:        ;
    endcase
  endtask

  // Write all four registers, then realign to the falling edge.
  task automatic apply_settings(input logic [STEP_W-1:0] step,
                                input logic signed [VAL_W-1:0] ox,
                                input logic signed [VAL_W-1:0] oy,
                                input logic [COUNT_W-1:0] lim);
    write_reg(CFG_PIXEL_STEP, {1'b0, step});
    write_reg(CFG_OFFSET_X, ox);
    write_reg(CFG_OFFSET_Y, oy);
    write_reg(CFG_MAX_ITER, {{(VAL_W - COUNT_W){1'b0}}, lim});
    settings_used++;
    @(negedge clk);
  endtask

  task automatic queue_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
    pixel_t p;
    p.x = x;
    p.y = y;
    pending_pixels.push_back(p);
    work_budget += 4 * ((iter_limit == 0) ? 1 : int'(iter_limit)) + 40;
  endtask

  // Block until every queued pixel has gone in and every result has come back.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0);
  endtask

  // Sender: offers queued pixels and records what each accepted beat should produce.
  always @(posedge clk) begin : pixel_driver
    pixel_t next_pixel;
    pixel_t sent;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sent.x = pixel_x;
        sent.y = pixel_y;
        expected_pixels.push_back(escape_time(sent));
        pixels_accepted <= pixels_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_pixels.size() != 0 &&
            $urandom_range(99) >= idle_pct(pixels_accepted, 1'b1)) begin
          next_pixel = pending_pixels.pop_front();
          in_valid <= 1'b1;
          pixel_x <= next_pixel.x;
          pixel_y <= next_pixel.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat against the oldest expectation.
  always @(posedge clk) begin : result_monitor
    amb_res_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_pixels.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("Unexpected result: count %0d escaped %0b at (%0d,%0d)",
                     iteration_count, escaped, out_x, out_y);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (iteration_count !== want.count || escaped !== want.escaped ||
              out_x !== want.x || out_y !== want.y) begin
            if (mismatches < REPORT_LIMIT)
              $display("Mismatch: expected count %0d escaped %0b at (%0d,%0d), %s",
                       want.count, want.escaped, want.x, want.y,
                       $sformatf("got count %0d escaped %0b at (%0d,%0d)",
                                 iteration_count, escaped, out_x, out_y));
            mismatches++;
          end
          if (want.escaped) escaped_seen++;
          else limit_hits++;
          if (int'(want.count) > longest_run) longest_run = want.count;
        end
      end
      // One long hold-off lets the core and the output register fill up.
      if (recv_hold_left > 0) begin
        out_ready <= 1'b0;
        recv_hold_left--;
      end else if (!hold_done && pixels_accepted == HOLD_AT_PIXEL) begin
        hold_done = 1'b1;
        recv_hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct(pixels_accepted, 1'b0));
      end
    end
  end

  // Watchdog sized from the work queued so far.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4 * work_budget + 50000) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // Stimulus: directed corners, then random settings with random pixels.
  initial begin
    int n;
    logic [STEP_W-1:0]       step;
    logic signed [VAL_W-1:0] ox;
    logic signed [VAL_W-1:0] oy;
    logic [COUNT_W-1:0]      lim;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: image corners, the center (c = 0), the largest coordinates and two more points.
    queue_pixel(0, 0);
    queue_pixel(799, 799);
    queue_pixel(400, 400);
    queue_pixel(1023, 1023);
    queue_pixel(0, 799);
    queue_pixel(799, 0);
    queue_pixel(400, 0);
    queue_pixel(200, 400);
    wait_drained();

    // A zero limit still runs one step; the corner escapes on that same step.
    apply_settings(DEFAULT_STEP, '0, '0, 10'd0);
    queue_pixel(400, 400);
    queue_pixel(0, 0);
    wait_drained();

    // Widest step with extreme pans: drives products and sums into saturation, including |-2^31|.
    apply_settings(WIDEST_STEP, MIN32, MAX32, 10'd1);
    queue_pixel(0, 0);
    queue_pixel(400, 400);
    queue_pixel(1023, 1023);
    queue_pixel(799, 0);
    wait_drained();

    // Zero step: c = 0 runs to the largest limit, then a far point escapes at once.
    apply_settings('0, '0, '0, 10'd1023);
    queue_pixel(123, 456);
    wait_drained();
    apply_settings('0, MAX32, MIN32, 10'd1023);
    queue_pixel(5, 5);
    wait_drained();

    // Random phases, each under its own register values.
    for (int ph = 0; ph < 10; ph++) begin
      step = STEP_W'($urandom_range(2000000, 20000));
      ox = $urandom_range(32'h2000_0000);
      ox = ox - 32'sh1000_0000;
      oy = $urandom_range(32'h2000_0000);
      oy = oy - 32'sh1000_0000;
      lim = COUNT_W'($urandom_range(80, 1));
      case (ph)
        3: step = WIDEST_STEP;
        4: begin
          ox = MIN32;
          oy = MAX32;
        end
        5: lim = 10'd1023;
        6: step = '0;
        7: begin
          ox = $urandom;
          oy = $urandom;
        end
        8: lim = COUNT_W'($urandom_range(3, 0));
        default: ;
      endcase
      apply_settings(step, ox, oy, lim);
      n = (ph == 5) ? 24 : 170;
      for (int i = 0; i < n; i++) begin
        queue_pixel(random_coord(), random_coord());
        // Halfway through one phase the sender stops until the block is empty.
        if (ph == 2 && i == n / 2) wait_drained();
      end
      wait_drained();
    end

    repeat (4 * int'(iter_limit) + 16) @(posedge clk);

    $display("Ran %0d pixels through %0d register settings, extremes and out-of-image included.",
             pixels_accepted, settings_used);
    $display("Results: %0d escaped, %0d stopped at the limit, longest run %0d iterations.",
             escaped_seen, limit_hits, longest_run);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
